FILE: hdl/srtf_pkg.sv
// ---------------------------------------------------------------------------
// srtf_pkg
// shared constants and types of the srtf schedule simulator
// ---------------------------------------------------------------------------
`default_nettype none

package srtf_pkg;

   localparam int MAX_PROCS_DEF = 8;

   localparam int ID_W    = 8;
   localparam int ARR_W   = 15;
   localparam int BURST_W = 12;
   localparam int TIME_W  = 17;   // internal clock, one bit wider than FIELD_W
   localparam int FIELD_W = 16;
   localparam int SUM_W   = 19;
   localparam int KIND_W  = 2;
   localparam int PCNT_W  = 4;

   localparam logic [KIND_W-1:0] KIND_GANTT  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RESULT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_TOTAL  = 2'd2;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SCAN,
      ST_STEP,
      ST_CLOSE,
      ST_RESULT,
      ST_TOTAL
   } state_type;

   // one entry as seen by the selection compare
   typedef struct packed {
      logic               done;
      logic [ARR_W-1:0]   arrival;
      logic [BURST_W-1:0] remaining;
   } entry_type;

   // running best of a scan
   typedef struct packed {
      logic               have;
      logic [ARR_W-1:0]   arrival;
      logic [BURST_W-1:0] remaining;
   } best_type;

endpackage

`default_nettype wire

FILE: hdl/srtf_if.sv
// ---------------------------------------------------------------------------
// srtf_if
// valid/ready channels for process records and schedule records
// ---------------------------------------------------------------------------
`default_nettype none

interface srtf_req_if;
   logic                          valid;
   logic                          ready;
   logic [srtf_pkg::ID_W-1:0]     proc_id;
   logic [srtf_pkg::ARR_W-1:0]    arrival_time;
   logic [srtf_pkg::BURST_W-1:0]  burst_length;
   logic                          final_entry;

   modport source (output valid, proc_id, arrival_time, burst_length, final_entry,
                   input ready);
   modport sink   (input valid, proc_id, arrival_time, burst_length, final_entry,
                   output ready);
endinterface

interface srtf_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [srtf_pkg::KIND_W-1:0]   record_kind;
   logic [srtf_pkg::ID_W-1:0]     owner_id;
   logic                          idle_segment;
   logic [srtf_pkg::FIELD_W-1:0]  segment_end;
   logic [srtf_pkg::FIELD_W-1:0]  completion_time;
   logic [srtf_pkg::FIELD_W-1:0]  turnaround;
   logic [srtf_pkg::FIELD_W-1:0]  waiting;
   logic [srtf_pkg::SUM_W-1:0]    total_turnaround;
   logic [srtf_pkg::SUM_W-1:0]    total_waiting;
   logic [srtf_pkg::PCNT_W-1:0]   process_count;
   logic                          last_result;

   modport source (output valid, record_kind, owner_id, idle_segment, segment_end,
                   completion_time, turnaround, waiting, total_turnaround,
                   total_waiting, process_count, last_result,
                   input ready);
   modport sink   (input valid, record_kind, owner_id, idle_segment, segment_end,
                   completion_time, turnaround, waiting, total_turnaround,
                   total_waiting, process_count, last_result,
                   output ready);
endinterface

`default_nettype wire

FILE: hdl/srtf_cmp.sv
// ---------------------------------------------------------------------------
// srtf_cmp
// shared selection compare: does this entry beat the running best
// ---------------------------------------------------------------------------
`default_nettype none

module srtf_cmp (
   input  srtf_pkg::entry_type                entry,
   input  srtf_pkg::best_type                 best,
   input  logic [srtf_pkg::TIME_W-1:0]        now,
   output logic                               take
);

   logic arrived;

   assign arrived = {{(srtf_pkg::TIME_W-srtf_pkg::ARR_W){1'b0}}, entry.arrival} <= now;

   // least remaining, then earlier arrival; equal keeps the lower index
   always_comb begin
      take = 1'b0;
      if (!entry.done && arrived) begin
         if (!best.have)
            take = 1'b1;
         else if (entry.remaining < best.remaining)
            take = 1'b1;
         else if (entry.remaining == best.remaining && entry.arrival < best.arrival)
            take = 1'b1;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/srtf_schedule_simulator.sv
// ---------------------------------------------------------------------------
// srtf_schedule_simulator
// preemptive shortest-remaining-time-first schedule simulator
// ---------------------------------------------------------------------------
// Process records (id, arrival, burst) are loaded one per cycle; the record
// with final_entry set starts the run and the block is not ready until the
// totals record has been handed to the output register. Records beyond
// MAX_PROCS are dropped, a zero burst counts as one. Each simulated time unit
// is a scan of the n loaded processes through the single shared selection
// compare, then a step that charges the unit and waits for the output
// register to free up when a Gantt segment closes. Idle units before
// arrivals are handled the same way. After the last completion the open
// segment, n result records in load order and one totals record drain at
// one per cycle when the sink is ready. The process and completion counts,
// clock, sums and done flags return to reset values after the totals record.
// ---------------------------------------------------------------------------
`default_nettype none

module srtf_schedule_simulator #(
   parameter int MAX_PROCS = srtf_pkg::MAX_PROCS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   srtf_req_if.sink   req_chan,
   srtf_rsp_if.source rsp_chan
);

   localparam int IdxW       = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int CntW       = $clog2(MAX_PROCS + 1);
   localparam int MaxResults = 4 * MAX_PROCS + 1;
   localparam int SegW       = $clog2(MaxResults + 1);
   localparam int TW         = srtf_pkg::TIME_W;
   localparam int FW         = srtf_pkg::FIELD_W;
   localparam int SW         = srtf_pkg::SUM_W;

   // entry storage
   logic [srtf_pkg::ID_W-1:0]    id_ff    [MAX_PROCS];
   logic [srtf_pkg::ARR_W-1:0]   arr_ff   [MAX_PROCS];
   logic [srtf_pkg::BURST_W-1:0] burst_ff [MAX_PROCS];
   logic [srtf_pkg::BURST_W-1:0] rem_ff   [MAX_PROCS];
   logic [FW-1:0]                fin_ff   [MAX_PROCS];
   logic [MAX_PROCS-1:0]         done_ff, done_in;

   // control state
   srtf_pkg::state_type state_ff, state_in;
   logic [CntW-1:0]  n_ff, n_in;
   logic [CntW-1:0]  idx_ff, idx_in;
   logic [CntW-1:0]  comp_ff, comp_in;
   logic [SegW-1:0]  seg_ff, seg_in;
   logic [TW-1:0]    now_ff, now_in;
   logic             open_v_ff, open_v_in;
   logic             open_idle_ff, open_idle_in;
   logic [srtf_pkg::ID_W-1:0] open_id_ff, open_id_in;
   logic [TW-1:0]    open_end_ff, open_end_in;
   logic [SW-1:0]    sum_t_ff, sum_t_in;
   logic [SW-1:0]    sum_w_ff, sum_w_in;
   srtf_pkg::best_type best_ff, best_in;
   logic [IdxW-1:0]  pick_ff, pick_in;

   // output register
   logic             out_v_ff, out_v_in;
   logic [srtf_pkg::KIND_W-1:0] o_kind_ff, o_kind_in;
   logic [srtf_pkg::ID_W-1:0]   o_id_ff, o_id_in;
   logic             o_idle_ff, o_idle_in;
   logic [FW-1:0]    o_seg_ff, o_seg_in;
   logic [FW-1:0]    o_comp_ff, o_comp_in;
   logic [FW-1:0]    o_tat_ff, o_tat_in;
   logic [FW-1:0]    o_wt_ff, o_wt_in;
   logic [SW-1:0]    o_tt_ff, o_tt_in;
   logic [SW-1:0]    o_tw_ff, o_tw_in;
   logic [srtf_pkg::PCNT_W-1:0] o_cnt_ff, o_cnt_in;
   logic             o_last_ff, o_last_in;

   // datapath helpers
   logic                 req_take;
   logic                 out_free;
   logic                 last_idx;
   logic [IdxW-1:0]      rd_idx;
   srtf_pkg::entry_type  rd_entry;
   logic                 take;
   logic [SegW-1:0]      seg_limit;
   logic                 seg_room;
   logic                 owner_change;
   logic                 step_emit;
   logic                 step_go;
   logic                 finishing;
   logic [TW-1:0]        now_next;
   logic [TW-1:0]        step_tat;
   logic [FW-1:0]        res_tat;
   logic                 close_emit;
   logic                 do_load;
   logic [srtf_pkg::BURST_W-1:0] load_burst;

   assign req_chan.ready = (state_ff == srtf_pkg::ST_LOAD);
   assign req_take       = req_chan.valid && req_chan.ready;
   assign out_free       = !out_v_ff || rsp_chan.ready;
   assign last_idx       = (idx_ff == CntW'(n_ff - CntW'(1)));

   // one read address: the scan / drain index, or the picked entry in a step
   assign rd_idx = (state_ff == srtf_pkg::ST_STEP) ? pick_ff : idx_ff[IdxW-1:0];
   assign rd_entry.done      = done_ff[rd_idx];
   assign rd_entry.arrival   = arr_ff[rd_idx];
   assign rd_entry.remaining = rem_ff[rd_idx];

   srtf_cmp u_cmp (
      .entry (rd_entry),
      .best  (best_ff),
      .now   (now_ff),
      .take  (take)
   );

   // segments are dropped once results and totals would no longer fit
   assign seg_limit = SegW'(MaxResults - 1) - SegW'(n_ff);
   assign seg_room  = seg_ff < seg_limit;

   assign owner_change = !open_v_ff || (open_idle_ff != !best_ff.have) ||
                         (open_id_ff != (best_ff.have ? id_ff[pick_ff] : '0));
   assign step_emit  = open_v_ff && owner_change && seg_room;
   assign step_go    = !step_emit || out_free;
   assign finishing  = best_ff.have && (rem_ff[pick_ff] == srtf_pkg::BURST_W'(1));
   assign now_next   = TW'(now_ff + TW'(1));
   assign step_tat   = TW'(now_next - TW'(arr_ff[pick_ff]));
   assign res_tat    = FW'(fin_ff[rd_idx] - FW'(arr_ff[rd_idx]));
   assign close_emit = open_v_ff && seg_room;

   assign do_load    = req_take && (n_ff < CntW'(MAX_PROCS));
   assign load_burst = (req_chan.burst_length == '0) ? srtf_pkg::BURST_W'(1)
                                                     : req_chan.burst_length;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         srtf_pkg::ST_LOAD:
            if (req_take && req_chan.final_entry) state_in = srtf_pkg::ST_SCAN;
         srtf_pkg::ST_SCAN:
            if (last_idx) state_in = srtf_pkg::ST_STEP;
         srtf_pkg::ST_STEP:
            if (step_go) begin
               if (finishing && (CntW'(comp_ff + CntW'(1)) == n_ff))
                  state_in = srtf_pkg::ST_CLOSE;
               else
                  state_in = srtf_pkg::ST_SCAN;
            end
         srtf_pkg::ST_CLOSE:
            if (!close_emit || out_free) state_in = srtf_pkg::ST_RESULT;
         srtf_pkg::ST_RESULT:
            if (out_free && last_idx) state_in = srtf_pkg::ST_TOTAL;
         srtf_pkg::ST_TOTAL:
            if (out_free) state_in = srtf_pkg::ST_LOAD;
         default:
            state_in = srtf_pkg::ST_LOAD;
      endcase
   end

   // datapath and outputs
   always_comb begin
      n_in         = n_ff;
      idx_in       = idx_ff;
      comp_in      = comp_ff;
      seg_in       = seg_ff;
      now_in       = now_ff;
      open_v_in    = open_v_ff;
      open_idle_in = open_idle_ff;
      open_id_in   = open_id_ff;
      open_end_in  = open_end_ff;
      sum_t_in     = sum_t_ff;
      sum_w_in     = sum_w_ff;
      best_in      = best_ff;
      pick_in      = pick_ff;
      done_in      = done_ff;

      out_v_in  = out_v_ff && !rsp_chan.ready;
      o_kind_in = o_kind_ff;
      o_id_in   = o_id_ff;
      o_idle_in = o_idle_ff;
      o_seg_in  = o_seg_ff;
      o_comp_in = o_comp_ff;
      o_tat_in  = o_tat_ff;
      o_wt_in   = o_wt_ff;
      o_tt_in   = o_tt_ff;
      o_tw_in   = o_tw_ff;
      o_cnt_in  = o_cnt_ff;
      o_last_in = o_last_ff;

      unique case (state_ff)
         srtf_pkg::ST_LOAD: begin
            if (do_load) begin
               n_in = CntW'(n_ff + CntW'(1));
               done_in[n_ff[IdxW-1:0]] = 1'b0;
            end
            if (req_take && req_chan.final_entry) begin
               idx_in       = '0;
               best_in.have = 1'b0;
               comp_in      = '0;
               seg_in       = '0;
            end
         end
         srtf_pkg::ST_SCAN: begin
            if (take) begin
               best_in.have      = 1'b1;
               best_in.arrival   = rd_entry.arrival;
               best_in.remaining = rd_entry.remaining;
               pick_in           = idx_ff[IdxW-1:0];
            end
            idx_in = CntW'(idx_ff + CntW'(1));
         end
         srtf_pkg::ST_STEP: begin
            if (step_go) begin
               // close the open segment when the owner changes
               if (step_emit) begin
                  out_v_in  = 1'b1;
                  o_kind_in = srtf_pkg::KIND_GANTT;
                  o_id_in   = open_idle_ff ? '0 : open_id_ff;
                  o_idle_in = open_idle_ff;
                  o_seg_in  = FW'(open_end_ff);
                  o_comp_in = '0;
                  o_tat_in  = '0;
                  o_wt_in   = '0;
                  o_tt_in   = '0;
                  o_tw_in   = '0;
                  o_cnt_in  = '0;
                  o_last_in = 1'b0;
                  seg_in    = SegW'(seg_ff + SegW'(1));
               end
               open_v_in    = 1'b1;
               open_idle_in = !best_ff.have;
               open_id_in   = best_ff.have ? id_ff[pick_ff] : '0;
               open_end_in  = now_next;
               now_in       = now_next;
               if (finishing) begin
                  done_in[pick_ff] = 1'b1;
                  comp_in  = CntW'(comp_ff + CntW'(1));
                  sum_t_in = SW'(sum_t_ff + SW'(step_tat));
                  sum_w_in = SW'(sum_w_ff + SW'(TW'(step_tat - TW'(burst_ff[pick_ff]))));
               end
               idx_in       = '0;
               best_in.have = 1'b0;
            end
         end
         srtf_pkg::ST_CLOSE: begin
            if (!close_emit || out_free) begin
               if (close_emit) begin
                  out_v_in  = 1'b1;
                  o_kind_in = srtf_pkg::KIND_GANTT;
                  o_id_in   = open_idle_ff ? '0 : open_id_ff;
                  o_idle_in = open_idle_ff;
                  o_seg_in  = FW'(open_end_ff);
                  o_comp_in = '0;
                  o_tat_in  = '0;
                  o_wt_in   = '0;
                  o_tt_in   = '0;
                  o_tw_in   = '0;
                  o_cnt_in  = '0;
                  o_last_in = 1'b0;
               end
               open_v_in = 1'b0;
               idx_in    = '0;
            end
         end
         srtf_pkg::ST_RESULT: begin
            if (out_free) begin
               out_v_in  = 1'b1;
               o_kind_in = srtf_pkg::KIND_RESULT;
               o_id_in   = id_ff[rd_idx];
               o_idle_in = 1'b0;
               o_seg_in  = '0;
               o_comp_in = fin_ff[rd_idx];
               o_tat_in  = res_tat;
               o_wt_in   = FW'(res_tat - FW'(burst_ff[rd_idx]));
               o_tt_in   = '0;
               o_tw_in   = '0;
               o_cnt_in  = '0;
               o_last_in = 1'b0;
               idx_in    = CntW'(idx_ff + CntW'(1));
            end
         end
         srtf_pkg::ST_TOTAL: begin
            if (out_free) begin
               out_v_in  = 1'b1;
               o_kind_in = srtf_pkg::KIND_TOTAL;
               o_id_in   = '0;
               o_idle_in = 1'b0;
               o_seg_in  = '0;
               o_comp_in = '0;
               o_tat_in  = '0;
               o_wt_in   = '0;
               o_tt_in   = sum_t_ff;
               o_tw_in   = sum_w_ff;
               o_cnt_in  = srtf_pkg::PCNT_W'(n_ff);
               o_last_in = 1'b1;
               // back to the reset picture for the next job
               n_in      = '0;
               comp_in   = '0;
               now_in    = '0;
               sum_t_in  = '0;
               sum_w_in  = '0;
               done_in   = '0;
            end
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= srtf_pkg::ST_LOAD;
         n_ff      <= '0;
         idx_ff    <= '0;
         comp_ff   <= '0;
         seg_ff    <= '0;
         now_ff    <= '0;
         open_v_ff <= 1'b0;
         sum_t_ff  <= '0;
         sum_w_ff  <= '0;
         best_ff   <= '0;
         done_ff   <= '0;
         out_v_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         n_ff      <= n_in;
         idx_ff    <= idx_in;
         comp_ff   <= comp_in;
         seg_ff    <= seg_in;
         now_ff    <= now_in;
         open_v_ff <= open_v_in;
         sum_t_ff  <= sum_t_in;
         sum_w_ff  <= sum_w_in;
         best_ff   <= best_in;
         done_ff   <= done_in;
         out_v_ff  <= out_v_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      open_idle_ff <= open_idle_in;
      open_id_ff   <= open_id_in;
      open_end_ff  <= open_end_in;
      pick_ff      <= pick_in;
      o_kind_ff    <= o_kind_in;
      o_id_ff      <= o_id_in;
      o_idle_ff    <= o_idle_in;
      o_seg_ff     <= o_seg_in;
      o_comp_ff    <= o_comp_in;
      o_tat_ff     <= o_tat_in;
      o_wt_ff      <= o_wt_in;
      o_tt_ff      <= o_tt_in;
      o_tw_ff      <= o_tw_in;
      o_cnt_ff     <= o_cnt_in;
      o_last_ff    <= o_last_in;
   end

   // entry storage writes: load, decrement and finish time
   always_ff @(posedge clock) begin
      if (state_ff == srtf_pkg::ST_LOAD && do_load) begin
         id_ff[n_ff[IdxW-1:0]]    <= req_chan.proc_id;
         arr_ff[n_ff[IdxW-1:0]]   <= req_chan.arrival_time;
         burst_ff[n_ff[IdxW-1:0]] <= load_burst;
         rem_ff[n_ff[IdxW-1:0]]   <= load_burst;
      end else if (state_ff == srtf_pkg::ST_STEP && step_go && best_ff.have) begin
         rem_ff[pick_ff] <= srtf_pkg::BURST_W'(rem_ff[pick_ff] - srtf_pkg::BURST_W'(1));
         if (finishing)
            fin_ff[pick_ff] <= FW'(now_next);
      end
   end

   // output channel
   assign rsp_chan.valid            = out_v_ff;
   assign rsp_chan.record_kind      = o_kind_ff;
   assign rsp_chan.owner_id         = o_id_ff;
   assign rsp_chan.idle_segment     = o_idle_ff;
   assign rsp_chan.segment_end      = o_seg_ff;
   assign rsp_chan.completion_time  = o_comp_ff;
   assign rsp_chan.turnaround       = o_tat_ff;
   assign rsp_chan.waiting          = o_wt_ff;
   assign rsp_chan.total_turnaround = o_tt_ff;
   assign rsp_chan.total_waiting    = o_tw_ff;
   assign rsp_chan.process_count    = o_cnt_ff;
   assign rsp_chan.last_result      = o_last_ff;

   // checks
   // the loaded count never exceeds the store
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      n_ff <= CntW'(MAX_PROCS))
      else $error("loaded count exceeds store depth");

   // completions never outrun the loaded entries
   a_comp_bound: assert property (@(posedge clock) disable iff (reset)
      comp_ff <= n_ff)
      else $error("completion count exceeds loaded count");

   // a scan only visits loaded entries
   a_scan_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == srtf_pkg::ST_SCAN) |-> (idx_ff < n_ff))
      else $error("scan index beyond loaded entries");

   // the last-result flag rides on the totals record only
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && o_last_ff) |-> (o_kind_ff == srtf_pkg::KIND_TOTAL))
      else $error("last flag on a non-totals record");

endmodule

`default_nettype wire

FILE: test/srtf_schedule_simulator_test.sv
// ---------------------------------------------------------------------------
// srtf_schedule_simulator_test
// self-checking bench for the srtf schedule simulator
// ---------------------------------------------------------------------------
// Jobs of process records are queued and driven over the request channel.
// A local scheduler model predicts the Gantt segments, the per-process
// results and the totals record of every job. Each record taken from the
// response channel is compared field by field with the oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srtf_schedule_simulator_test;

   localparam int NPROC     = srtf_pkg::MAX_PROCS_DEF;
   localparam int IDLE_SPAN = 300000;  // cycles without a transaction

   typedef struct packed {
      logic [srtf_pkg::ID_W-1:0]    pid;
      logic [srtf_pkg::ARR_W-1:0]   arr;
      logic [srtf_pkg::BURST_W-1:0] burst;
      logic                         last;
   } proc_rec_type;

   typedef struct packed {
      logic [srtf_pkg::KIND_W-1:0]  kind;
      logic [srtf_pkg::ID_W-1:0]    owner;
      logic                         idle;
      logic [srtf_pkg::FIELD_W-1:0] seg_end;
      logic [srtf_pkg::FIELD_W-1:0] comp;
      logic [srtf_pkg::FIELD_W-1:0] tat;
      logic [srtf_pkg::FIELD_W-1:0] wt;
      logic [srtf_pkg::SUM_W-1:0]   ttot;
      logic [srtf_pkg::SUM_W-1:0]   wtot;
      logic [srtf_pkg::PCNT_W-1:0]  cnt;
      logic                         last;
   } sched_rec_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   srtf_req_if req_chan ();
   srtf_rsp_if rsp_chan ();

   srtf_schedule_simulator u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   always #5 clock = ~clock;

   // stimulus and expectation stores
   proc_rec_type  pending_procs[$];
   sched_rec_type expected_records[$];

   // scheduler model state, one job at a time
   proc_rec_type job_procs[$];

   int     send_idle_pct = 0;
   int     recv_stall_pct = 0;
   bit     hold_sender = 1'b0;
   bit     req_fired = 1'b0;
   int     mismatches = 0;
   int     quiet_cycles = 0;

   // ------------------------------------------------------------------
   // model: run the whole job when its final record is accepted
   // ------------------------------------------------------------------
   task automatic schedule_job();
      int             n, done_cnt, pick;
      int             now;
      int             rem[NPROC];
      int             fin[NPROC];
      bit             done[NPROC];
      bit             seg_open;
      int             seg_owner;     // 256 marks idle
      int             seg_stop;
      int             owner;
      int             tat, wt, sum_tat, sum_wt;
      sched_rec_type  r;
      n = job_procs.size();
      for (int i = 0; i < n; i++) begin
         rem[i]  = (job_procs[i].burst == 0) ? 1 : job_procs[i].burst;
         done[i] = 1'b0;
      end
      now = 0; done_cnt = 0; seg_open = 1'b0; seg_owner = 0; seg_stop = 0;
      sum_tat = 0; sum_wt = 0;
      while (done_cnt < n) begin
         pick = -1;
         for (int i = 0; i < n; i++) begin
            if (!done[i] && job_procs[i].arr <= now) begin
               if (pick < 0 || rem[i] < rem[pick] ||
                   (rem[i] == rem[pick] && job_procs[i].arr < job_procs[pick].arr))
                  pick = i;
            end
         end
         owner = (pick < 0) ? 256 : job_procs[pick].pid;
         if (!(seg_open && seg_owner == owner)) begin
            if (seg_open) begin
               r = '0;
               r.kind = srtf_pkg::KIND_GANTT; r.owner = seg_owner[7:0];
               r.idle = seg_owner[8]; r.seg_end = seg_stop[15:0];
               expected_records.push_back(r);
            end
            seg_open = 1'b1;
            seg_owner = owner;
         end
         now++;
         seg_stop = now;
         if (pick >= 0) begin
            rem[pick]--;
            if (rem[pick] == 0) begin
               fin[pick] = now;
               done[pick] = 1'b1;
               tat = now - job_procs[pick].arr;
               sum_tat += tat;
               sum_wt  += tat - ((job_procs[pick].burst == 0) ? 1 : job_procs[pick].burst);
               done_cnt++;
            end
         end
      end
      if (seg_open) begin
         r = '0;
         r.kind = srtf_pkg::KIND_GANTT; r.owner = seg_owner[7:0];
         r.idle = seg_owner[8]; r.seg_end = seg_stop[15:0];
         expected_records.push_back(r);
      end
      for (int i = 0; i < n; i++) begin
         r = '0;
         tat = fin[i] - job_procs[i].arr;
         wt = tat - ((job_procs[i].burst == 0) ? 1 : job_procs[i].burst);
         r.kind = srtf_pkg::KIND_RESULT; r.owner = job_procs[i].pid;
         r.comp = fin[i][15:0]; r.tat = tat[15:0]; r.wt = wt[15:0];
         expected_records.push_back(r);
      end
      r = '0;
      r.kind = srtf_pkg::KIND_TOTAL;
      r.ttot = sum_tat[srtf_pkg::SUM_W-1:0]; r.wtot = sum_wt[srtf_pkg::SUM_W-1:0];
      r.cnt = n[srtf_pkg::PCNT_W-1:0]; r.last = 1'b1;
      expected_records.push_back(r);
      job_procs.delete();
   endtask

   // accept path into the model; extra records past the store size are dropped
   task automatic take_proc(input proc_rec_type p);
      if (job_procs.size() < NPROC)
         job_procs.push_back(p);
      if (p.last)
         schedule_job();
   endtask

   // ------------------------------------------------------------------
   // job builders
   // ------------------------------------------------------------------
   task automatic queue_proc(input int pid, input int arr, input int burst, input bit last);
      proc_rec_type p;
      p.pid   = pid[srtf_pkg::ID_W-1:0];
      p.arr   = arr[srtf_pkg::ARR_W-1:0];
      p.burst = burst[srtf_pkg::BURST_W-1:0];
      p.last  = last;
      pending_procs.push_back(p);
   endtask

   // random job; long bursts and late arrivals are kept rare to bound run time
   task automatic queue_random_job();
      int n, arr, burst, base;
      n = $urandom_range(1, 10);   // sometimes more than the store holds
      base = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 300) : 0;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 9))
            0: burst = $urandom_range(100, 400);
            1: burst = 1;
            default: burst = $urandom_range(1, 20);
         endcase
         arr = base + (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 60));
         queue_proc($urandom_range(0, 255), arr, burst, i == n - 1);
      end
   endtask

   task automatic wait_drained();
      while (pending_procs.size() != 0 || expected_records.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // driver: valid and payload move at the falling edge
   // ------------------------------------------------------------------
   initial begin
      req_chan.valid = 1'b0;
      req_chan.proc_id = '0;
      req_chan.arrival_time = '0;
      req_chan.burst_length = '0;
      req_chan.final_entry = 1'b0;
      rsp_chan.ready = 1'b0;
   end

   always @(negedge clock) begin
      // retire the transaction accepted at the last rising edge
      if (!reset && req_fired) begin
         take_proc(pending_procs.pop_front());
      end
      if (!reset && req_chan.valid && !req_fired) begin
         // the offered transaction still waits, keep it on the bus
      end else if (!reset && !hold_sender && pending_procs.size() != 0 &&
                   $urandom_range(0, 99) >= send_idle_pct) begin
         req_chan.valid        <= 1'b1;
         req_chan.proc_id      <= pending_procs[0].pid;
         req_chan.arrival_time <= pending_procs[0].arr;
         req_chan.burst_length <= pending_procs[0].burst;
         req_chan.final_entry  <= pending_procs[0].last;
      end else begin
         req_chan.valid <= 1'b0;
      end
      rsp_chan.ready <= !reset && ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // ------------------------------------------------------------------
   // monitor: compare every response transaction at the rising edge
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      sched_rec_type got, want;
      req_fired <= !reset && req_chan.valid && req_chan.ready;
      if (!reset) begin
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.kind = rsp_chan.record_kind;   got.owner = rsp_chan.owner_id;
            got.idle = rsp_chan.idle_segment;  got.seg_end = rsp_chan.segment_end;
            got.comp = rsp_chan.completion_time;
            got.tat = rsp_chan.turnaround;     got.wt = rsp_chan.waiting;
            got.ttot = rsp_chan.total_turnaround;
            got.wtot = rsp_chan.total_waiting;
            got.cnt = rsp_chan.process_count;  got.last = rsp_chan.last_result;
            if (expected_records.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected record kind=%0d owner=%0d", got.kind, got.owner);
            end else begin
               want = expected_records.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch: exp kind=%0d own=%0d idle=%0d end=%0d ",
                               "comp=%0d tat=%0d wt=%0d tt=%0d tw=%0d n=%0d last=%0d | ",
                               "got kind=%0d own=%0d idle=%0d end=%0d comp=%0d ",
                               "tat=%0d wt=%0d tt=%0d tw=%0d n=%0d last=%0d"},
                              want.kind, want.owner, want.idle, want.seg_end, want.comp,
                              want.tat, want.wt, want.ttot, want.wtot, want.cnt,
                              want.last, got.kind, got.owner, got.idle, got.seg_end,
                              got.comp, got.tat, got.wt, got.ttot, got.wtot, got.cnt,
                              got.last);
               end
            end
         end
      end
   end

   // watchdog on stalled traffic
   always @(posedge clock) begin
      if (quiet_cycles >= IDLE_SPAN) begin
         $display("tb: failure");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // sequence of phases
   // ------------------------------------------------------------------
   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: single process, field extremes, zero burst, idle gaps
      queue_proc(8'hFF, 0, 1, 1'b1);
      queue_proc(8'h00, 5, 0, 1'b1);                 // idle lead-in, burst of zero
      queue_proc(8'hA5, 32767, 3, 1'b1);             // latest arrival
      queue_proc(8'h5A, 0, 4095, 1'b1);              // longest burst
      // preemption, tie on remaining broken by arrival then by load order
      queue_proc(1, 0, 8, 1'b0);
      queue_proc(2, 1, 4, 1'b0);
      queue_proc(3, 2, 2, 1'b0);
      queue_proc(4, 2, 2, 1'b0);
      queue_proc(5, 20, 1, 1'b1);                    // idle gap before it
      // store overflow: ten records, the last two dropped
      for (int i = 0; i < 10; i++)
         queue_proc(16 + i, i, 3 + (i % 3), i == 9);
      wait_drained();

      // sender is held off while a random job is queued, then released
      hold_sender = 1'b1;
      queue_random_job();
      repeat (10) @(posedge clock);
      hold_sender = 1'b0;
      wait_drained();

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
            default: begin send_idle_pct = 8; recv_stall_pct = 8; end
         endcase
         for (int j = 0; j < 10; j++)
            queue_random_job();
         wait_drained();
      end

      if (mismatches == 0 && expected_records.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

`default_nettype wire
